/* rtl/core/mpa_pkg.sv */
// Package for the 2-D max pooling unit with argmax.
// Holds configuration register indexes, field widths and reset values.
// No dependencies.
package mpa_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;
    localparam int POOL_W = 4;
    localparam int DIM_W = 10;
    localparam int MAPS_W = 16;
    localparam int OUT_W = 9;

    localparam logic [CFG_AW-1:0] CFG_POOL_ROWS = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_POOL_COLS = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_IN_ROWS = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_IN_COLS = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_MAP_COUNT = 3'd4;

    localparam logic [POOL_W-1:0] RST_POOL_ROWS = 4'd2;
    localparam logic [POOL_W-1:0] RST_POOL_COLS = 4'd2;
    localparam logic [DIM_W-1:0] RST_IN_ROWS = 10'd32;
    localparam logic [DIM_W-1:0] RST_IN_COLS = 10'd32;
    localparam logic [MAPS_W-1:0] RST_MAP_COUNT = 16'd1;

endpackage

/* rtl/core/max_pool_2d_argmax_unit.sv */
// Top level of the streaming 2-D max pooling unit with argmax.
// Uses mpa_pkg for register indexes, widths and reset values.
// Holds the column memory, the position counters and the output register.

// The unit takes one input word per cycle in raster order, map after map, and
// gives one result word when the bottom-right sample of a pooling window
// arrives. Per output column a running maximum and its window offset live in
// one synchronous memory of MAX_COLS entries; each sample reads its entry in
// the accept cycle and writes it back when stage 1 advances, with forwarding
// when two consecutive samples share a column. A result passes through stage 1
// and the output register. After any configuration write the window position
// is recomputed by a bit-serial divider, during which no input word is
// accepted; otherwise one word is taken every cycle unless the output stalls.
module max_pool_2d_argmax_unit #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512,
    parameter int MAX_POOL = 8,
    parameter int DATA_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mpa_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [mpa_pkg::CFG_DW-1:0]         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [DATA_WIDTH-1:0]       i_sample,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [DATA_WIDTH-1:0]       o_pooled_value,
    output logic [mpa_pkg::OUT_W-1:0]          o_max_row,
    output logic [mpa_pkg::OUT_W-1:0]          o_max_col,
    output logic [mpa_pkg::OUT_W-1:0]          o_out_row,
    output logic [mpa_pkg::OUT_W-1:0]          o_out_col,
    output logic                               o_map_last,
    output logic                               o_job_last
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int PW = $clog2(MAX_POOL);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RSW = RCW + 6;
    localparam int CSW = CCW + 6;
    localparam int PXW = mpa_pkg::POOL_W + 1;
    localparam int DW = (RW > CW) ? RW : CW;
    localparam int DCW = $clog2(DW + 1);
    localparam int AW0 = (RW > CW) ? RW : CW;
    localparam int AW = ((AW0 > mpa_pkg::OUT_W) ? AW0 : mpa_pkg::OUT_W) + 1;
    localparam int MW = DATA_WIDTH + 2 * PW;
    localparam int MCW = mpa_pkg::MAPS_W + 1;

    // Configuration registers and their effective values.
    logic [mpa_pkg::POOL_W-1:0] r_pool_rows, r_pool_cols;
    logic [mpa_pkg::DIM_W-1:0]  r_in_rows, r_in_cols;
    logic [mpa_pkg::MAPS_W-1:0] r_map_count;
    logic [mpa_pkg::POOL_W-1:0] pr_e, pc_e;
    logic [RCW-1:0]             ir_e;
    logic [CCW-1:0]             ic_e;
    logic [mpa_pkg::MAPS_W-1:0] mc_e;

    always_comb begin
        pr_e = (r_pool_rows == '0) ? mpa_pkg::POOL_W'(1) :
               (int'(r_pool_rows) > MAX_POOL) ? mpa_pkg::POOL_W'(MAX_POOL) : r_pool_rows;
        pc_e = (r_pool_cols == '0) ? mpa_pkg::POOL_W'(1) :
               (int'(r_pool_cols) > MAX_POOL) ? mpa_pkg::POOL_W'(MAX_POOL) : r_pool_cols;
        ir_e = (r_in_rows == '0) ? RCW'(1) :
               (int'(r_in_rows) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(r_in_rows);
        ic_e = (r_in_cols == '0) ? CCW'(1) :
               (int'(r_in_cols) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(r_in_cols);
        mc_e = (r_map_count == '0) ? mpa_pkg::MAPS_W'(1) : r_map_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_rows <= mpa_pkg::RST_POOL_ROWS;
            r_pool_cols <= mpa_pkg::RST_POOL_COLS;
            r_in_rows   <= mpa_pkg::RST_IN_ROWS;
            r_in_cols   <= mpa_pkg::RST_IN_COLS;
            r_map_count <= mpa_pkg::RST_MAP_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mpa_pkg::CFG_POOL_ROWS: r_pool_rows <= i_cfg_data[mpa_pkg::POOL_W-1:0];
                mpa_pkg::CFG_POOL_COLS: r_pool_cols <= i_cfg_data[mpa_pkg::POOL_W-1:0];
                mpa_pkg::CFG_IN_ROWS:   r_in_rows   <= i_cfg_data[mpa_pkg::DIM_W-1:0];
                mpa_pkg::CFG_IN_COLS:   r_in_cols   <= i_cfg_data[mpa_pkg::DIM_W-1:0];
                mpa_pkg::CFG_MAP_COUNT: r_map_count <= i_cfg_data[mpa_pkg::MAPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Position counters: absolute row and column, offset inside the window,
    // window index and window base.
    logic [RW-1:0]             r_r, r_wr, r_rb;
    logic [CW-1:0]             r_c, r_wc, r_cb;
    logic [PW-1:0]             r_dr, r_dc;
    logic [mpa_pkg::MAPS_W-1:0] r_map;

    // Bit-serial divider that rebuilds the window position after a write.
    logic [DCW-1:0]             r_div_cnt;
    logic [DW-1:0]              r_div_rn, r_div_cn, r_div_rq, r_div_cq;
    logic [mpa_pkg::POOL_W-1:0] r_div_rrem, r_div_crem;
    logic [PXW-1:0]             div_rsh, div_csh;
    logic [mpa_pkg::POOL_W-1:0] n_div_rrem, n_div_crem;
    logic [DW-1:0]              n_div_rq, n_div_cq;
    logic                       div_busy;

    assign div_busy = (r_div_cnt != '0);

    always_comb begin
        div_rsh = {r_div_rrem, r_div_rn[DW-1]};
        div_csh = {r_div_crem, r_div_cn[DW-1]};
        if (div_rsh >= PXW'(pr_e)) begin
            n_div_rrem = mpa_pkg::POOL_W'(div_rsh - PXW'(pr_e));
            n_div_rq   = {r_div_rq[DW-2:0], 1'b1};
        end else begin
            n_div_rrem = mpa_pkg::POOL_W'(div_rsh);
            n_div_rq   = {r_div_rq[DW-2:0], 1'b0};
        end
        if (div_csh >= PXW'(pc_e)) begin
            n_div_crem = mpa_pkg::POOL_W'(div_csh - PXW'(pc_e));
            n_div_cq   = {r_div_cq[DW-2:0], 1'b1};
        end else begin
            n_div_crem = mpa_pkg::POOL_W'(div_csh);
            n_div_cq   = {r_div_cq[DW-2:0], 1'b0};
        end
    end

    // Pipeline control.
    logic r_s1_v, r_s1_wr_en, r_s1_emit;
    logic r_o_valid;
    logic s1_adv, acc;

    assign s1_adv  = !r_s1_v || !r_s1_emit || !r_o_valid || i_ready;
    assign o_ready = s1_adv && !div_busy;
    assign acc     = i_valid && o_ready;

    // Stage 0 decode of the current position.
    logic           s0_region, s0_first, s0_last, s0_mlast, s0_jlast;
    logic           c_end, r_end, dc_wrap, dr_wrap, mc_end;

    always_comb begin
        s0_region = (RSW'(r_rb) + RSW'(pr_e) <= RSW'(ir_e)) &&
                    (CSW'(r_cb) + CSW'(pc_e) <= CSW'(ic_e));
        s0_first  = (r_dr == '0) && (r_dc == '0);
        s0_last   = (PXW'(r_dr) + PXW'(1) == PXW'(pr_e)) &&
                    (PXW'(r_dc) + PXW'(1) == PXW'(pc_e));
        mc_end    = (MCW'(r_map) + MCW'(1) >= MCW'(mc_e));
        s0_mlast  = (RSW'(r_rb) + RSW'(pr_e) + RSW'(pr_e) > RSW'(ir_e)) &&
                    (CSW'(r_cb) + CSW'(pc_e) + CSW'(pc_e) > CSW'(ic_e));
        s0_jlast  = s0_mlast && mc_end;
        c_end     = (CSW'(r_c) + CSW'(1) >= CSW'(ic_e));
        r_end     = (RSW'(r_r) + RSW'(1) >= RSW'(ir_e));
        dc_wrap   = (PXW'(r_dc) + PXW'(1) >= PXW'(pc_e));
        dr_wrap   = (PXW'(r_dr) + PXW'(1) >= PXW'(pr_e));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r       <= '0;
            r_c       <= '0;
            r_dr      <= '0;
            r_dc      <= '0;
            r_wr      <= '0;
            r_wc      <= '0;
            r_rb      <= '0;
            r_cb      <= '0;
            r_map     <= '0;
            r_div_cnt <= '0;
        end else if (i_cfg_we) begin
            r_div_cnt  <= DCW'(DW);
            r_div_rn   <= DW'(r_r);
            r_div_cn   <= DW'(r_c);
            r_div_rrem <= '0;
            r_div_crem <= '0;
            r_div_rq   <= '0;
            r_div_cq   <= '0;
        end else if (div_busy) begin
            r_div_cnt  <= r_div_cnt - DCW'(1);
            r_div_rn   <= {r_div_rn[DW-2:0], 1'b0};
            r_div_cn   <= {r_div_cn[DW-2:0], 1'b0};
            r_div_rrem <= n_div_rrem;
            r_div_crem <= n_div_crem;
            r_div_rq   <= n_div_rq;
            r_div_cq   <= n_div_cq;
            if (r_div_cnt == DCW'(1)) begin
                r_dr <= PW'(n_div_rrem);
                r_dc <= PW'(n_div_crem);
                r_wr <= RW'(n_div_rq);
                r_wc <= CW'(n_div_cq);
                r_rb <= r_r - RW'(n_div_rrem);
                r_cb <= r_c - CW'(n_div_crem);
            end
        end else if (acc) begin
            if (c_end) begin
                r_c  <= '0;
                r_dc <= '0;
                r_wc <= '0;
                r_cb <= '0;
                if (r_end) begin
                    r_r   <= '0;
                    r_dr  <= '0;
                    r_wr  <= '0;
                    r_rb  <= '0;
                    r_map <= mc_end ? '0 : r_map + mpa_pkg::MAPS_W'(1);
                end else begin
                    r_r <= r_r + RW'(1);
                    if (dr_wrap) begin
                        r_dr <= '0;
                        r_wr <= r_wr + RW'(1);
                        r_rb <= r_rb + RW'(pr_e);
                    end else begin
                        r_dr <= r_dr + PW'(1);
                    end
                end
            end else begin
                r_c <= r_c + CW'(1);
                if (dc_wrap) begin
                    r_dc <= '0;
                    r_wc <= r_wc + CW'(1);
                    r_cb <= r_cb + CW'(pc_e);
                end else begin
                    r_dc <= r_dc + PW'(1);
                end
            end
        end
    end

    // Stage 1 registers.
    logic signed [DATA_WIDTH-1:0] r_s1_sample;
    logic [PW-1:0]                r_s1_dr, r_s1_dc;
    logic [RW-1:0]                r_s1_rb, r_s1_wr;
    logic [CW-1:0]                r_s1_cb, r_s1_wc;
    logic                         r_s1_first, r_s1_mlast, r_s1_jlast, r_s1_hit;
    logic [MW-1:0]                r_s1_fwd;
    logic [MW-1:0]                r_rd;
    logic [MW-1:0]                r_mem [MAX_COLS];

    logic [MW-1:0]                s1_cur, s1_new;
    logic signed [DATA_WIDTH-1:0] s1_cur_max;
    logic [PW-1:0]                s1_cur_col;
    logic                         s1_upd, mem_we;

    always_comb begin
        s1_cur     = r_s1_hit ? r_s1_fwd : r_rd;
        s1_cur_max = s1_cur[MW-1 -: DATA_WIDTH];
        s1_cur_col = s1_cur[PW-1:0];
        s1_upd     = r_s1_first || (r_s1_sample > s1_cur_max) ||
                     ((r_s1_sample == s1_cur_max) && (r_s1_dc < s1_cur_col));
        s1_new     = s1_upd ? {r_s1_sample, r_s1_dr, r_s1_dc} : s1_cur;
    end

    assign mem_we = r_s1_v && r_s1_wr_en && s1_adv;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_s1_wc] <= s1_new;
        end
        if (acc) begin
            r_rd <= r_mem[r_wc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_adv) begin
            r_s1_v <= acc;
        end
        if (acc) begin
            r_s1_sample <= i_sample;
            r_s1_dr     <= r_dr;
            r_s1_dc     <= r_dc;
            r_s1_rb     <= r_rb;
            r_s1_cb     <= r_cb;
            r_s1_wr     <= r_wr;
            r_s1_wc     <= r_wc;
            r_s1_first  <= s0_first;
            r_s1_wr_en  <= s0_region;
            r_s1_emit   <= s0_region && s0_last;
            r_s1_mlast  <= s0_mlast;
            r_s1_jlast  <= s0_jlast;
            r_s1_hit    <= r_s1_v && r_s1_wr_en && (r_s1_wc == r_wc);
            r_s1_fwd    <= s1_new;
        end
    end

    // Output register.
    logic signed [DATA_WIDTH-1:0] r_o_value;
    logic [mpa_pkg::OUT_W-1:0]    r_o_max_row, r_o_max_col, r_o_out_row, r_o_out_col;
    logic                         r_o_map_last, r_o_job_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_s1_v && r_s1_emit && s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
        if (r_s1_v && r_s1_emit && s1_adv) begin
            r_o_value    <= s1_new[MW-1 -: DATA_WIDTH];
            r_o_max_row  <= mpa_pkg::OUT_W'(AW'(r_s1_rb) + AW'(s1_new[2*PW-1:PW]));
            r_o_max_col  <= mpa_pkg::OUT_W'(AW'(r_s1_cb) + AW'(s1_new[PW-1:0]));
            r_o_out_row  <= mpa_pkg::OUT_W'(AW'(r_s1_wr));
            r_o_out_col  <= mpa_pkg::OUT_W'(AW'(r_s1_wc));
            r_o_map_last <= r_s1_mlast;
            r_o_job_last <= r_s1_jlast;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_pooled_value = r_o_value;
    assign o_max_row      = r_o_max_row;
    assign o_max_col      = r_o_max_col;
    assign o_out_row      = r_o_out_row;
    assign o_out_col      = r_o_out_col;
    assign o_map_last     = r_o_map_last;
    assign o_job_last     = r_o_job_last;

    // Checks.
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !o_ready)
        else $error("input accepted while the window position is rebuilt");

    a_offset_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !div_busy |-> (PXW'(r_dr) < PXW'(pr_e)) && (PXW'(r_dc) < PXW'(pc_e)))
        else $error("window offset outside the pool size");

    a_base_matches_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !div_busy |-> (r_rb + RW'(r_dr) == r_r) && (r_cb + CW'(r_dc) == r_c))
        else $error("window base and offset disagree with the position");

    a_job_implies_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_job_last |-> r_o_map_last)
        else $error("end of job without end of map");

    a_hit_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_s1_v && r_s1_wr_en && (r_s1_wc == r_wc) |=> r_s1_hit)
        else $error("same-column forwarding missed");

endmodule

/* verif/max_pool_2d_argmax_unit_test.sv */
// Self-checking testbench for max_pool_2d_argmax_unit, the streaming 2-D max pooling unit.
// Depends on mpa_pkg and the unit's RTL; a scoreboard class predicts each pooled word
// from the accepted samples and the register settings.
module max_pool_2d_argmax_unit_test;
    import mpa_pkg::*;

    localparam int DATA_WIDTH = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 600;
    localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic [OUT_W-1:0]             max_row;
        logic [OUT_W-1:0]             max_col;
        logic [OUT_W-1:0]             out_row;
        logic [OUT_W-1:0]             out_col;
        logic                         map_last;
        logic                         job_last;
    } pool_result_t;

    class pool_scoreboard;
        logic [POOL_W-1:0] pool_rows_reg = RST_POOL_ROWS;
        logic [POOL_W-1:0] pool_cols_reg = RST_POOL_COLS;
        logic [DIM_W-1:0]  in_rows_reg = RST_IN_ROWS;
        logic [DIM_W-1:0]  in_cols_reg = RST_IN_COLS;
        logic [MAPS_W-1:0] maps_reg = RST_MAP_COUNT;
        bit signed [DATA_WIDTH-1:0] run_max [512];
        bit [2:0]          run_arg_row [512];
        bit [2:0]          run_arg_col [512];
        int unsigned       row_pos = 0;
        int unsigned       col_pos = 0;
        int unsigned       map_pos = 0;
        pool_result_t      windows_due [$];
        int unsigned       mismatches = 0;
        int unsigned       results_seen = 0;

        static function int unsigned bound(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function int unsigned eff_pool_rows();
            return bound(pool_rows_reg, 8);
        endfunction

        function int unsigned map_items();
            return bound(in_rows_reg, 512) * bound(in_cols_reg, 512);
        endfunction

        function bit at_map_start();
            return row_pos == 0 && col_pos == 0;
        endfunction

        function bit at_band_start();
            return col_pos == 0 && (row_pos % eff_pool_rows()) == 0;
        endfunction

        function int unsigned outstanding();
            return windows_due.size();
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_POOL_ROWS: pool_rows_reg = data[POOL_W-1:0];
                CFG_POOL_COLS: pool_cols_reg = data[POOL_W-1:0];
                CFG_IN_ROWS:   in_rows_reg = data[DIM_W-1:0];
                CFG_IN_COLS:   in_cols_reg = data[DIM_W-1:0];
                CFG_MAP_COUNT: maps_reg = data[MAPS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [DATA_WIDTH-1:0] s);
            int unsigned pr, pc, ir, ic, mc, orows, ocols, wr, wc, dr, dc;
            pool_result_t res;
            pr = bound(pool_rows_reg, 8);
            pc = bound(pool_cols_reg, 8);
            ir = bound(in_rows_reg, 512);
            ic = bound(in_cols_reg, 512);
            mc = bound(maps_reg, 65535);
            orows = ir / pr;
            ocols = ic / pc;
            if (row_pos < orows * pr && col_pos < ocols * pc) begin
                wr = row_pos / pr;
                wc = col_pos / pc;
                dr = row_pos % pr;
                dc = col_pos % pc;
                if ((dr == 0 && dc == 0) || s > run_max[wc] ||
                    (s == run_max[wc] && dc < run_arg_col[wc])) begin
                    run_max[wc] = s;
                    run_arg_row[wc] = 3'(dr);
                    run_arg_col[wc] = 3'(dc);
                end
                if (dr == pr - 1 && dc == pc - 1) begin
                    res.value = run_max[wc];
                    res.max_row = OUT_W'(wr * pr + run_arg_row[wc]);
                    res.max_col = OUT_W'(wc * pc + run_arg_col[wc]);
                    res.out_row = OUT_W'(wr);
                    res.out_col = OUT_W'(wc);
                    res.map_last = (wr == orows - 1 && wc == ocols - 1);
                    res.job_last = res.map_last && (map_pos + 1 >= mc);
                    windows_due.push_back(res);
                end
            end
            if (col_pos + 1 >= ic) begin
                col_pos = 0;
                if (row_pos + 1 >= ir) begin
                    row_pos = 0;
                    map_pos = (map_pos + 1 >= mc) ? 0 : map_pos + 1;
                end else begin
                    row_pos = row_pos + 1;
                end
            end else begin
                col_pos = col_pos + 1;
            end
        endfunction

        function void check_result(pool_result_t got);
            pool_result_t want;
            if (windows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Pooled word with no window pending: value %0d row %0d col %0d",
                             got.value, got.out_row, got.out_col);
                return;
            end
            want = windows_due.pop_front();
            results_seen++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Pooled word %0d mismatch (expected/actual):", results_seen);
                    $display("  value %0d/%0d max_row %0d/%0d max_col %0d/%0d",
                             want.value, got.value, want.max_row, got.max_row,
                             want.max_col, got.max_col);
                    $display("  out_row %0d/%0d out_col %0d/%0d map_last %0b/%0b job_last %0b/%0b",
                             want.out_row, got.out_row, want.out_col, got.out_col,
                             want.map_last, got.map_last, want.job_last, got.job_last);
                end
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CFG_AW-1:0]            i_cfg_addr;
    logic [CFG_DW-1:0]            i_cfg_data;
    logic                         i_valid;
    logic                         o_ready;
    logic signed [DATA_WIDTH-1:0] i_sample;
    logic                         o_valid;
    logic                         i_ready;
    logic signed [DATA_WIDTH-1:0] o_pooled_value;
    logic [OUT_W-1:0]             o_max_row;
    logic [OUT_W-1:0]             o_max_col;
    logic [OUT_W-1:0]             o_out_row;
    logic [OUT_W-1:0]             o_out_col;
    logic                         o_map_last;
    logic                         o_job_last;

    pool_scoreboard board = new();
    int unsigned    quiet_cycles = 0;
    int unsigned    samples_sent = 0;
    int unsigned    settings_used = 0;
    bit             send_gaps = 1'b0;
    bit             ready_stalls = 1'b0;

    max_pool_2d_argmax_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pooled_value (o_pooled_value),
        .o_max_row      (o_max_row),
        .o_max_col      (o_max_col),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_map_last     (o_map_last),
        .o_job_last     (o_job_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ready_stalls ? ($urandom_range(99) >= 31) : 1'b1;
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_valid && i_ready)
            board.check_result({o_pooled_value, o_max_row, o_max_col, o_out_row, o_out_col,
                                o_map_last, o_job_last});
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timed out with %0d pooled words still pending.", board.outstanding());
        $display("[max_pool_2d_argmax_unit] ERROR");
        $finish;
    end

    function automatic logic signed [DATA_WIDTH-1:0] rand_sample();
        case ($urandom_range(9))
            0: return ($urandom_range(1) == 0) ? 16'sh7FFF : 16'sh8000;
            1: return ($urandom_range(1) == 0) ? 16'sh0000 : 16'shFFFF;
            2, 3, 4: return 16'(int'($urandom_range(4)) - 2);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] rand_pool();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'($urandom_range(15, 9));
            2: return 16'hFFF0 | 16'($urandom_range(8, 1));
            default: return 16'($urandom_range(8, 1));
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] rand_dim(input int unsigned hi);
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFC00 | 16'($urandom_range(hi, 1));
            default: return 16'($urandom_range(hi, 1));
        endcase
    endfunction

    task automatic send_sample(input logic signed [DATA_WIDTH-1:0] v);
        while (send_gaps && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (!o_ready);
        board.note_sample(v);
        samples_sent++;
    endtask

    task automatic send_items(input int unsigned n);
        repeat (n) send_sample(rand_sample());
    endtask

    task automatic finish_map();
        while (!board.at_map_start()) send_sample(rand_sample());
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        board.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic set_job(input logic [CFG_DW-1:0] pr, pc, ir, ic, mc);
        write_reg(CFG_POOL_ROWS, pr);
        write_reg(CFG_POOL_COLS, pc);
        write_reg(CFG_IN_ROWS, ir);
        write_reg(CFG_IN_COLS, ic);
        write_reg(CFG_MAP_COUNT, mc);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic signed [DATA_WIDTH-1:0] tie_map [15];
        int unsigned random_start;
        int unsigned n;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_sample   <= '0;
        i_ready    <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A 3x5 map with 2x2 windows: the last row and column are dropped, the first
        // window ties between its top-right and bottom-left samples, the second is flat.
        tie_map = '{16'sd100, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                    16'sh7FFF, -16'sd5, 16'sh8000, 16'sh8000, 16'sh7FFF,
                    16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        set_job(16'd2, 16'd2, 16'd3, 16'd5, 16'd1);
        foreach (tie_map[k]) send_sample(tie_map[k]);
        drain();

        // Out-of-range register values clamp; this long stretch runs with no idling.
        set_job(16'd0, 16'd9, 16'd0, 16'hFFFF, 16'd0);
        send_items(512);
        drain();

        send_gaps    <= 1'b1;
        ready_stalls <= 1'b1;
        set_job(16'd1, 16'd1, 16'd1, 16'd512, 16'd1);
        send_items(512);
        drain();
        set_job(16'd1, 16'd1, 16'd512, 16'd1, 16'd1);
        send_items(512);
        drain();

        // A window taller than the map gives no words; one exactly as tall gives a single row of words.
        set_job(16'd8, 16'd8, 16'd7, 16'd9, 16'd2);
        send_items(126);
        drain();
        set_job(16'd8, 16'd8, 16'd8, 16'd16, 16'd1);
        send_items(128);
        drain();

        // Shrinking the map count below the current map index ends the job early.
        write_reg(CFG_UNUSED, 16'hFFFF);
        set_job(16'd2, 16'd2, 16'd2, 16'd2, 16'hFFFF);
        send_items(12);
        drain();
        write_reg(CFG_MAP_COUNT, 16'd2);
        i_cfg_we <= 1'b0;
        send_items(8);
        drain();

        // Cutting the row count below the current row mid-map wraps at the row's end.
        set_job(16'd2, 16'd2, 16'd6, 16'd6, 16'd1);
        send_items(24);
        drain();
        write_reg(CFG_IN_ROWS, 16'd3);
        i_cfg_we <= 1'b0;
        finish_map();
        drain();

        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_ITEMS) begin
            set_job(rand_pool(), rand_pool(), rand_dim(12), rand_dim(16),
                    16'($urandom_range(3)));
            send_gaps    <= ($urandom_range(4) != 0);
            ready_stalls <= ($urandom_range(4) != 0);
            n = $urandom_range(3 * board.map_items(), 1);
            send_items(n);
            if ($urandom_range(2) == 0) begin
                while (!board.at_band_start()) send_sample(rand_sample());
                drain();
                case ($urandom_range(2))
                    0: write_reg(CFG_IN_ROWS, rand_dim(12));
                    1: write_reg(CFG_IN_COLS, rand_dim(16));
                    default: write_reg(CFG_MAP_COUNT, 16'($urandom_range(3)));
                endcase
                i_cfg_we <= 1'b0;
            end
            finish_map();
            drain();
        end

        $display("Sent %0d samples under %0d register settings and checked %0d pooled words,",
                 samples_sent, settings_used, board.results_seen);
        $display("including ties, dropped edges, clamped registers and mid-map changes.");
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("[max_pool_2d_argmax_unit] OK");
        else
            $display("[max_pool_2d_argmax_unit] ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/mpa_pkg.sv
rtl/core/max_pool_2d_argmax_unit.sv
verif/max_pool_2d_argmax_unit_test.sv
